/* rtl/core/bbsm_pkg.sv */
// Package: shared types, constants and helpers of the button box mapper.
package bbsm_pkg;

  localparam logic [7:0] CTR = 8'd128;

  localparam logic [7:0] LVL_FULL  = 8'd140;
  localparam logic [7:0] LVL_MID   = 8'd94;
  localparam logic [7:0] LVL_LIGHT = 8'd49;

  typedef struct packed {
    logic [3:0] direction_keys;
    logic [3:0] c_keys;
    logic [3:0] modifier_keys;
    logic [1:0] trigger_keys;
    logic [5:0] face_keys;
  } bbsm_in_t;

  typedef struct packed {
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [7:0] cstick_x;
    logic [7:0] cstick_y;
    logic [7:0] analog_left;
    logic [7:0] analog_right;
    logic [3:0] dpad;
    logic [7:0] buttons_out;
  } bbsm_out_t;

  typedef struct packed {
    logic dn;
    logic up;
    logic rt;
    logic lf;
  } bbsm_dir_t;

  function automatic logic [7:0] co(input logic [6:0] n);
    co = CTR + {1'b0, n};
  endfunction

  function automatic logic [7:0] mirror(input logic [7:0] v);
    mirror = 8'(9'd256 - {1'b0, v});
  endfunction

endpackage

/* rtl/core/bbsm_in_if.sv */
// Interface: input channel carrying one button box sample.
interface bbsm_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] direction_keys;
  logic [3:0] c_keys;
  logic [3:0] modifier_keys;
  logic [1:0] trigger_keys;
  logic [5:0] face_keys;

  modport source (output valid, direction_keys, c_keys, modifier_keys, trigger_keys,
                  face_keys, input ready);
  modport sink (input valid, direction_keys, c_keys, modifier_keys, trigger_keys,
                face_keys, output ready);
endinterface

/* rtl/core/bbsm_out_if.sv */
// Interface: result channel carrying one controller report.
interface bbsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [7:0] cstick_x;
  logic [7:0] cstick_y;
  logic [7:0] analog_left;
  logic [7:0] analog_right;
  logic [3:0] dpad;
  logic [7:0] buttons_out;

  modport source (output valid, stick_x, stick_y, cstick_x, cstick_y, analog_left,
                  analog_right, dpad, buttons_out, input ready);
  modport sink (input valid, stick_x, stick_y, cstick_x, cstick_y, analog_left,
                analog_right, dpad, buttons_out, output ready);
endinterface

/* rtl/core/bbsm_cfg_if.sv */
// Interface: configuration write channel for the reactivation mode register.
interface bbsm_cfg_if;
  logic valid;
  logic ready;
  logic reactivation_mode;

  modport source (output valid, reactivation_mode, input ready);
  modport sink (input valid, reactivation_mode, output ready);
endinterface

/* rtl/core/bbsm_socd.sv */
// SOCD cleaner: press history, recency and lockout state, opposing direction resolve.
module bbsm_socd (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              mode,
  input  logic [3:0]        keys,
  output bbsm_pkg::bbsm_dir_t clean
);
  import bbsm_pkg::*;

  logic [3:0] prev_pressed_r;
  logic       right_newest_r, up_newest_r;
  logic [3:0] locked_out_r;
  logic       right_newest_nxt, up_newest_nxt;
  logic [3:0] locked_out_nxt;
  logic       lf, rt, up, dn, plf, prt, pup, pdn;

  assign {dn, up, rt, lf}     = keys;
  assign {pdn, pup, prt, plf} = prev_pressed_r;

  always_comb begin
    right_newest_nxt = right_newest_r;
    if (rt && !prt) right_newest_nxt = 1'b1;
    if (lf && !plf) right_newest_nxt = 1'b0;
    up_newest_nxt = up_newest_r;
    if (up && !pup) up_newest_nxt = 1'b1;
    if (dn && !pdn) up_newest_nxt = 1'b0;

    locked_out_nxt = locked_out_r | {pdn && up && dn && !pup,
                                     pup && up && dn && !pdn,
                                     prt && lf && rt && !plf,
                                     plf && lf && rt && !prt};
    locked_out_nxt = locked_out_nxt & keys;

    clean = keys;
    if (mode) begin
      if (lf && rt) begin
        if (right_newest_nxt) clean.lf = 1'b0;
        else clean.rt = 1'b0;
      end
      if (up && dn) begin
        if (up_newest_nxt) clean.dn = 1'b0;
        else clean.up = 1'b0;
      end
    end else begin
      clean = keys & ~locked_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pressed_r <= '0;
      right_newest_r <= 1'b0;
      up_newest_r    <= 1'b0;
      locked_out_r   <= '0;
    end else if (adv) begin
      prev_pressed_r <= keys;
      right_newest_r <= right_newest_nxt;
      up_newest_r    <= up_newest_nxt;
      locked_out_r   <= locked_out_nxt;
    end
  end

endmodule

/* rtl/core/bbsm_map.sv */
// Report mapper: stick and C-stick coordinates, trigger levels, D-pad and buttons.
module bbsm_map (
  input  bbsm_pkg::bbsm_dir_t dir,
  input  bbsm_pkg::bbsm_in_t  smp,
  output bbsm_pkg::bbsm_out_t rpt
);
  import bbsm_pkg::*;

  logic       cl, cr, cu, cd, mx, my, ms, ls, tl, tr;
  logic       vert, horiz, cvert, choriz;
  logic [7:0] sx, sy, cx, cy;

  assign {cd, cu, cr, cl} = smp.c_keys;
  assign {ls, ms, my, mx} = smp.modifier_keys;
  assign {tr, tl}         = smp.trigger_keys;

  assign vert   = dir.up || dir.dn;
  assign horiz  = dir.lf || dir.rt;
  assign cvert  = cu != cd;
  assign choriz = cl != cr;

  always_comb begin
    sx = co(7'd0);
    sy = co(7'd0);
    if (vert && horiz) begin
      if (tl || tr) begin
        if (mx == my) begin
          sx = co(7'd56); sy = co(7'd56);
        end else if (mx) begin
          sx = co(7'd51); sy = co(7'd30);
        end else begin
          sx = co(7'd68); sy = co(7'd40);
        end
      end else if (mx != my) begin
        if (mx) begin
          if (cd) begin
            sx = co(7'd61); sy = co(7'd49);
          end else if (cl) begin
            sx = co(7'd66); sy = co(7'd42);
          end else if (cu) begin
            sx = co(7'd71); sy = co(7'd35);
          end else if (cr) begin
            sx = co(7'd72); sy = co(7'd27);
          end else begin
            sx = co(7'd40); sy = co(7'd26);
          end
        end else begin
          if (cd) begin
            sx = co(7'd49); sy = co(7'd61);
          end else if (cl) begin
            sx = co(7'd42); sy = co(7'd66);
          end else if (cu) begin
            sx = co(7'd35); sy = co(7'd71);
          end else if (cr) begin
            sx = co(7'd27); sy = co(7'd75);
          end else begin
            sx = co(7'd38); sy = co(7'd49);
          end
        end
      end else begin
        sx = co(7'd56); sy = co(7'd56);
      end
    end else if (horiz) begin
      if (mx == my) sx = co(7'd80);
      else if (mx) sx = co(7'd53);
      else sx = co(7'd26);
    end else if (vert) begin
      if (mx == my) sy = co(7'd80);
      else if (mx) sy = co(7'd43);
      else sy = co(7'd51);
    end
    if (horiz && !dir.rt) sx = mirror(sx);
    if (vert && !dir.up) sy = mirror(sy);

    cx = co(7'd0);
    cy = co(7'd0);
    if (mx && my) begin
      cx = co(7'd0); cy = co(7'd0);
    end else if (cvert && choriz) begin
      cx = co(7'd56); cy = co(7'd56);
    end else if (choriz) begin
      if (mx) begin
        cx = co(7'd56); cy = co(7'd56);
      end else if (my) begin
        cx = co(7'd56); cy = mirror(co(7'd56));
      end else begin
        cx = co(7'd80);
      end
    end else if (cvert) begin
      cy = co(7'd80);
    end
    if (choriz && cl) cx = mirror(cx);
    if (cvert && cd) cy = mirror(cy);

    rpt.stick_x      = sx;
    rpt.stick_y      = sy;
    rpt.cstick_x     = cx;
    rpt.cstick_y     = cy;
    rpt.analog_left  = tl ? LVL_FULL : ms ? LVL_MID : ls ? LVL_LIGHT : 8'd0;
    rpt.analog_right = tr ? LVL_FULL : 8'd0;
    rpt.dpad         = (mx && my) ? {cr, cu, cl, cd} : 4'd0;
    rpt.buttons_out  = {smp.face_keys[5], tr, tl, smp.face_keys[4:0]};
  end

endmodule

/* rtl/core/button_box_to_stick_mapper_socd.sv */
// Top level: button box to controller report mapper with SOCD cleaning.
// A sample waits in the input register, its report in the result register.
// Throughput: one item per cycle unless the output stalls; the two registers
// let a new sample enter while a finished report waits downstream.
// Reset (rst_n low, synchronous) empties both registers, clears the press,
// recency and lockout state and selects lockout mode.
module button_box_to_stick_mapper_socd (
  input logic        clk,
  input logic        rst_n,
  bbsm_in_if.sink    in_ch,
  bbsm_out_if.source out_ch,
  bbsm_cfg_if.sink   cfg_ch
);
  import bbsm_pkg::*;

  logic      mode_r;
  logic      s1_v_r, out_v_r;
  bbsm_in_t  s1_data_r, in_data;
  bbsm_out_t out_data_r, rpt;
  bbsm_dir_t clean;
  logic      adv;

  assign in_data = '{direction_keys: in_ch.direction_keys,
                     c_keys:         in_ch.c_keys,
                     modifier_keys:  in_ch.modifier_keys,
                     trigger_keys:   in_ch.trigger_keys,
                     face_keys:      in_ch.face_keys};

  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;
  assign cfg_ch.ready = 1'b1;

  bbsm_socd u_socd (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .mode  (mode_r),
    .keys  (s1_data_r.direction_keys),
    .clean (clean)
  );

  bbsm_map u_map (
    .dir (clean),
    .smp (s1_data_r),
    .rpt (rpt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) mode_r <= cfg_ch.reactivation_mode;
      if (in_ch.ready) s1_v_r <= in_ch.valid;
      if (adv) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_data_r <= in_data;
    if (adv) out_data_r <= rpt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.stick_x      = out_data_r.stick_x;
  assign out_ch.stick_y      = out_data_r.stick_y;
  assign out_ch.cstick_x     = out_data_r.cstick_x;
  assign out_ch.cstick_y     = out_data_r.cstick_y;
  assign out_ch.analog_left  = out_data_r.analog_left;
  assign out_ch.analog_right = out_data_r.analog_right;
  assign out_ch.dpad         = out_data_r.dpad;
  assign out_ch.buttons_out  = out_data_r.buttons_out;

endmodule

/* bench/button_box_to_stick_mapper_socd_tb.sv */
// Testbench: drives directed and random button samples through the mapper and checks every report.
`timescale 1ns / 100ps

module button_box_to_stick_mapper_socd_tb;
  import bbsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  class report_scoreboard;
    bit newest_wins_mode;
    logic [3:0] last_keys;
    logic right_wins;
    logic up_wins;
    logic [3:0] held_out;
    bbsm_out_t expected_reports[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      newest_wins_mode = 1'b0;
      last_keys = '0;
      right_wins = 1'b0;
      up_wins = 1'b0;
      held_out = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_mode(bit m);
      newest_wins_mode = m;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function logic [7:0] at(int n);
      return 8'(CTR + n);
    endfunction

    function logic [7:0] flip(logic [7:0] v);
      return 8'd0 - v;
    endfunction

    function bbsm_out_t map_sample(bbsm_in_t s);
      logic [3:0] d;
      logic [3:0] lk;
      logic lf, rt, up, dn;
      logic cl, cr, cu, cd, mx, my, tl, tr;
      logic vert, horiz, cvert, choriz;
      logic [7:0] sx, sy, cx, cy;
      bbsm_out_t r;
      d = s.direction_keys;
      {dn, up, rt, lf} = d;
      {cd, cu, cr, cl} = s.c_keys;
      mx = s.modifier_keys[0];
      my = s.modifier_keys[1];
      tl = s.trigger_keys[0];
      tr = s.trigger_keys[1];

      if (rt && !last_keys[1]) right_wins = 1'b1;
      if (lf && !last_keys[0]) right_wins = 1'b0;
      if (up && !last_keys[2]) up_wins = 1'b1;
      if (dn && !last_keys[3]) up_wins = 1'b0;

      lk = held_out;
      if (last_keys[0] && lf && rt && !last_keys[1]) lk[0] = 1'b1;
      if (last_keys[1] && lf && rt && !last_keys[0]) lk[1] = 1'b1;
      if (last_keys[2] && up && dn && !last_keys[3]) lk[2] = 1'b1;
      if (last_keys[3] && up && dn && !last_keys[2]) lk[3] = 1'b1;
      lk &= d;
      held_out = lk;
      last_keys = d;

      if (newest_wins_mode) begin
        if (lf && rt) begin
          if (right_wins) lf = 1'b0;
          else rt = 1'b0;
        end
        if (up && dn) begin
          if (up_wins) dn = 1'b0;
          else up = 1'b0;
        end
      end else begin
        if (lk[0]) lf = 1'b0;
        if (lk[1]) rt = 1'b0;
        if (lk[2]) up = 1'b0;
        if (lk[3]) dn = 1'b0;
      end

      vert = up || dn;
      horiz = lf || rt;

      if (vert && horiz) begin
        if (tl || tr) begin
          if (mx == my) begin sx = at(56); sy = at(56); end
          else if (mx) begin sx = at(51); sy = at(30); end
          else begin sx = at(68); sy = at(40); end
        end else if (mx != my) begin
          if (mx) begin
            if (cd) begin sx = at(61); sy = at(49); end
            else if (cl) begin sx = at(66); sy = at(42); end
            else if (cu) begin sx = at(71); sy = at(35); end
            else if (cr) begin sx = at(72); sy = at(27); end
            else begin sx = at(40); sy = at(26); end
          end else begin
            if (cd) begin sx = at(49); sy = at(61); end
            else if (cl) begin sx = at(42); sy = at(66); end
            else if (cu) begin sx = at(35); sy = at(71); end
            else if (cr) begin sx = at(27); sy = at(75); end
            else begin sx = at(38); sy = at(49); end
          end
        end else begin
          sx = at(56);
          sy = at(56);
        end
      end else if (horiz) begin
        sy = at(0);
        if (mx == my) sx = at(80);
        else if (mx) sx = at(53);
        else sx = at(26);
      end else if (vert) begin
        sx = at(0);
        if (mx == my) sy = at(80);
        else if (mx) sy = at(43);
        else sy = at(51);
      end else begin
        sx = at(0);
        sy = at(0);
      end

      if (horiz && !rt) sx = flip(sx);
      if (vert && !up) sy = flip(sy);

      cvert = cu != cd;
      choriz = cl != cr;
      if (mx && my) begin cx = at(0); cy = at(0); end
      else if (cvert && choriz) begin cx = at(56); cy = at(56); end
      else if (choriz) begin
        if (mx) begin cx = at(56); cy = at(56); end
        else if (my) begin cx = at(56); cy = at(-56); end
        else begin cx = at(80); cy = at(0); end
      end else if (cvert) begin cx = at(0); cy = at(80); end
      else begin cx = at(0); cy = at(0); end

      if (choriz && cl) cx = flip(cx);
      if (cvert && cd) cy = flip(cy);

      r.stick_x = sx;
      r.stick_y = sy;
      r.cstick_x = cx;
      r.cstick_y = cy;
      r.analog_left = tl ? LVL_FULL : s.modifier_keys[2] ? LVL_MID :
                      s.modifier_keys[3] ? LVL_LIGHT : 8'd0;
      r.analog_right = tr ? LVL_FULL : 8'd0;
      r.dpad = (mx && my) ? {cr, cu, cl, cd} : 4'd0;
      r.buttons_out = {s.face_keys[5], tr, tl, s.face_keys[4:0]};
      return r;
    endfunction

    function void note_sample(bbsm_in_t s);
      expected_reports.push_back(map_sample(s));
    endfunction

    function void field_ok(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_report(bbsm_out_t got);
      bbsm_out_t exp_r;
      if (expected_reports.size() == 0) begin
        $error("report arrived with none expected");
        errors++;
        return;
      end
      exp_r = expected_reports.pop_front();
      checked++;
      field_ok("stick_x", exp_r.stick_x, got.stick_x);
      field_ok("stick_y", exp_r.stick_y, got.stick_y);
      field_ok("cstick_x", exp_r.cstick_x, got.cstick_x);
      field_ok("cstick_y", exp_r.cstick_y, got.cstick_y);
      field_ok("analog_left", exp_r.analog_left, got.analog_left);
      field_ok("analog_right", exp_r.analog_right, got.analog_right);
      field_ok("dpad", exp_r.dpad, got.dpad);
      field_ok("buttons_out", exp_r.buttons_out, got.buttons_out);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bbsm_in_if in_ch();
  bbsm_out_if out_ch();
  bbsm_cfg_if cfg_ch();

  button_box_to_stick_mapper_socd dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  report_scoreboard sb = new();

  bit calm;
  bit hold_request;
  int unsigned items_sent;
  int unsigned mode_writes;
  int unsigned cycle_count;
  bbsm_in_t last_sample;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bbsm_out_t got;
      got.stick_x = out_ch.stick_x;
      got.stick_y = out_ch.stick_y;
      got.cstick_x = out_ch.cstick_x;
      got.cstick_y = out_ch.cstick_y;
      got.analog_left = out_ch.analog_left;
      got.analog_right = out_ch.analog_right;
      got.dpad = out_ch.dpad;
      got.buttons_out = out_ch.buttons_out;
      sb.check_report(got);
    end
  end

  // Output ready: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic bbsm_in_t sample(logic [3:0] d, logic [3:0] c, logic [3:0] m,
                                      logic [1:0] t, logic [5:0] f);
    bbsm_in_t s;
    s.direction_keys = d;
    s.c_keys = c;
    s.modifier_keys = m;
    s.trigger_keys = t;
    s.face_keys = f;
    return s;
  endfunction

  // Mostly press/release one key at a time so lockouts build up; some noise.
  function automatic bbsm_in_t random_sample(bbsm_in_t prev);
    bbsm_in_t s;
    s = prev;
    if ($urandom_range(0, 4) == 0) begin
      s = bbsm_in_t'(20'($urandom));
    end else begin
      s.direction_keys[$urandom_range(0, 3)] ^= 1'b1;
      if ($urandom_range(0, 3) == 0) s.direction_keys[$urandom_range(0, 3)] ^= 1'b1;
      if ($urandom_range(0, 2) == 0) s.c_keys = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) s.modifier_keys = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) s.trigger_keys = 2'($urandom_range(0, 3));
      s.face_keys = 6'($urandom_range(0, 63));
    end
    return s;
  endfunction

  task automatic drive_item(input bbsm_in_t it);
    int unsigned gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.direction_keys <= it.direction_keys;
    in_ch.c_keys <= it.c_keys;
    in_ch.modifier_keys <= it.modifier_keys;
    in_ch.trigger_keys <= it.trigger_keys;
    in_ch.face_keys <= it.face_keys;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(it);
    last_sample = it;
    items_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reactivation_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_mode(m);
    mode_writes++;
  endtask

  initial begin
    bit mode;
    calm = 1'b0;
    hold_request = 1'b0;
    items_sent = 0;
    mode_writes = 0;
    cycle_count = 0;
    last_sample = '0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.direction_keys <= '0;
    in_ch.c_keys <= '0;
    in_ch.modifier_keys <= '0;
    in_ch.trigger_keys <= '0;
    in_ch.face_keys <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.reactivation_mode <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // lockout mode after reset: extremes, lockouts, stick table corners
    write_mode(1'b0);
    drive_item(sample(4'h0, 4'h0, 4'h0, 2'd0, 6'd0));
    drive_item(sample(4'hf, 4'hf, 4'hf, 2'd3, 6'd63));
    drive_item(sample(4'h1, 4'h0, 4'h0, 2'd0, 6'd1));
    drive_item(sample(4'h3, 4'h0, 4'h0, 2'd0, 6'd2));
    drive_item(sample(4'h3, 4'h0, 4'h1, 2'd0, 6'd4));
    drive_item(sample(4'h2, 4'h0, 4'h2, 2'd0, 6'd8));
    drive_item(sample(4'h4, 4'h0, 4'h0, 2'd1, 6'd16));
    drive_item(sample(4'hc, 4'h0, 4'h0, 2'd2, 6'd32));
    drive_item(sample(4'h9, 4'h8, 4'h1, 2'd0, 6'd0));
    drive_item(sample(4'h9, 4'h1, 4'h1, 2'd0, 6'd0));
    drive_item(sample(4'h9, 4'h4, 4'h1, 2'd0, 6'd0));
    drive_item(sample(4'h9, 4'h2, 4'h1, 2'd0, 6'd0));
    drive_item(sample(4'h9, 4'h0, 4'h1, 2'd0, 6'd0));
    drive_item(sample(4'h6, 4'h8, 4'h2, 2'd0, 6'd0));
    drive_item(sample(4'h6, 4'h1, 4'h2, 2'd0, 6'd0));
    drive_item(sample(4'h6, 4'h4, 4'h2, 2'd0, 6'd0));
    drive_item(sample(4'h6, 4'h2, 4'h2, 2'd0, 6'd0));
    drive_item(sample(4'h6, 4'h0, 4'h2, 2'd0, 6'd0));
    drive_item(sample(4'h5, 4'h0, 4'h1, 2'd1, 6'd0));
    drive_item(sample(4'h5, 4'h0, 4'h2, 2'd2, 6'd0));
    drive_item(sample(4'h0, 4'h5, 4'h3, 2'd0, 6'd0));
    drive_item(sample(4'h0, 4'h1, 4'h2, 2'd0, 6'd0));
    drive_item(sample(4'h0, 4'h6, 4'h5, 2'd0, 6'd0));
    drive_item(sample(4'h0, 4'hf, 4'h8, 2'd0, 6'd0));
    settle();

    // newest press wins: simultaneous presses, then a later right press
    write_mode(1'b1);
    drive_item(sample(4'h0, 4'h0, 4'h0, 2'd0, 6'd0));
    drive_item(sample(4'hf, 4'h0, 4'h0, 2'd0, 6'd0));
    drive_item(sample(4'h1, 4'h0, 4'h0, 2'd0, 6'd0));
    drive_item(sample(4'h3, 4'h0, 4'h0, 2'd0, 6'd0));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      mode = (ph % 2 == 0);
      write_mode(mode);
      if (ph == 3) calm = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 100) hold_request = 1'b1;
        drive_item(random_sample(last_sample));
      end
      settle();
    end

    repeat (4) @(posedge clk);
    $display("covered %0d samples and %0d reports in both cleaning modes, %0d mode writes,",
             items_sent, sb.checked, mode_writes);
    $display("with random stalls on both sides and one long output hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bbsm_pkg.sv
rtl/core/bbsm_in_if.sv
rtl/core/bbsm_out_if.sv
rtl/core/bbsm_cfg_if.sv
rtl/core/bbsm_socd.sv
rtl/core/bbsm_map.sv
rtl/core/button_box_to_stick_mapper_socd.sv
bench/button_box_to_stick_mapper_socd_tb.sv
